### hw/rtl/pcfk_pkg.sv
// shared types, constants and tables of the planar chain kinematics block
`default_nettype none
package pcfk_pkg;
  localparam int MaxJoints = 8;
  localparam int CordicSteps = 16;
  localparam int AccW = 40;
  localparam int VecW = 36;
  localparam logic [29:0] GainQ30 = 30'd652032874;

  localparam logic [2:0] REG_JOINTS = 3'd0;

  typedef struct packed {
    logic [2:0] joint_index;
    logic signed [15:0] delta_angle;
    logic apply_now;
  } in_req_t;

  typedef struct packed {
    logic [2:0] out_joint;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [15:0] own_angle;
    logic last_joint;
  } out_req_t;

  // queue entry: a snapshot of the joint angles to be walked
  typedef struct packed {
    logic [MaxJoints-1:0][15:0] angles;
    logic [3:0] count;
  } job_t;

  function automatic logic signed [33:0] atan_at(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sh20000000;  5'd1: r = 34'sh12E4051E;
      5'd2: r = 34'sh09FB385B;  5'd3: r = 34'sh051111D4;
      5'd4: r = 34'sh028B0D43;  5'd5: r = 34'sh0145D7E1;
      5'd6: r = 34'sh00A2F61E;  5'd7: r = 34'sh00517C55;
      5'd8: r = 34'sh0028BE53;  5'd9: r = 34'sh00145F2F;
      5'd10: r = 34'sh000A2F98; 5'd11: r = 34'sh000517CC;
      5'd12: r = 34'sh00028BE6; 5'd13: r = 34'sh000145F3;
      5'd14: r = 34'sh0000A2FA; 5'd15: r = 34'sh0000517D;
      5'd16: r = 34'sh000028BE; 5'd17: r = 34'sh0000145F;
      5'd18: r = 34'sh00000A30; 5'd19: r = 34'sh00000518;
      5'd20: r = 34'sh0000028C; 5'd21: r = 34'sh00000146;
      5'd22: r = 34'sh000000A3; 5'd23: r = 34'sh00000051;
      default: r = 34'sh0;
    endcase
    return r;
  endfunction

  function automatic logic signed [19:0] to_pos(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] r;
    logic signed [AccW-9:0] v;
    r = acc + AccW'(128);
    v = r[AccW-1:8];
    if (v > (AccW-8)'(524287)) return 20'sh7FFFF;
    if (v < -(AccW-8)'(524288)) return 20'sh80000;
    return v[19:0];
  endfunction
endpackage
`default_nettype wire

### hw/rtl/pcfk_front.sv
// front end: angle store and job issue
`default_nettype none
module pcfk_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pcfk_pkg::in_req_t in_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [3:0] joints_in_use,
  output pcfk_pkg::job_t job,
  output logic job_valid,
  input  wire logic job_ready
);
  logic [pcfk_pkg::MaxJoints-1:0][15:0] angles;
  logic [pcfk_pkg::MaxJoints-1:0][15:0] angles_next;
  logic [3:0] n;

  assign in_ready = !job_valid || job_ready;

  always_comb begin
    angles_next = angles;
    angles_next[in_data.joint_index] = angles[in_data.joint_index] + in_data.delta_angle;
    if (joints_in_use < 4'd2) n = 4'd2;
    else if (joints_in_use > 4'(pcfk_pkg::MaxJoints)) n = 4'(pcfk_pkg::MaxJoints);
    else n = joints_in_use;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angles <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) job_valid <= 1'b0;
      if (in_valid && in_ready) begin
        angles <= angles_next;
        if (in_data.apply_now) begin
          job_valid <= 1'b1;
          job.angles <= angles_next;
          job.count <= n;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/pcfk_back.sv
// back end: iterative cordic walk of the chain
`default_nettype none
module pcfk_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pcfk_pkg::job_t job,
  input  wire logic job_valid,
  output logic job_ready,
  input  wire logic [7:1][15:0] link_len,
  output pcfk_pkg::out_req_t out_data,
  output logic out_valid,
  input  wire logic out_ready
);
  localparam logic [1:0] S_IDLE = 2'd0, S_LOAD = 2'd1, S_ROT = 2'd2, S_EMIT = 2'd3;
  logic [1:0] state;
  pcfk_pkg::job_t cur;
  logic [2:0] k;
  logic [4:0] step;
  logic [15:0] sum;
  logic [45:0] prod;
  logic signed [pcfk_pkg::VecW-1:0] x, y;
  logic signed [33:0] z;
  logic signed [pcfk_pkg::AccW-1:0] accx, accy;
  logic signed [33:0] zs;
  logic signed [pcfk_pkg::VecW-1:0] x0;

  assign job_ready = state == S_IDLE;

  always_comb begin
    prod = 46'(link_len[k]) * 46'(pcfk_pkg::GainQ30) + 46'(1 << 21);
    x0 = pcfk_pkg::VecW'(prod[45:22]);
    zs = {{2{sum[15]}}, sum, 16'h0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (job_valid) begin
          cur <= job;
          k <= 3'd0;
          sum <= 16'h0;
          accx <= '0;
          accy <= '0;
          state <= S_EMIT;
        end
        S_LOAD: begin
          y <= '0;
          step <= 5'd0;
          if (zs > 34'sh40000000) begin
            z <= zs - 34'sh80000000; x <= -x0;
          end else if (zs < -34'sh40000000) begin
            z <= zs + 34'sh80000000; x <= -x0;
          end else begin
            z <= zs; x <= x0;
          end
          state <= S_ROT;
        end
        S_ROT: begin
          if (!z[33]) begin
            x <= x - (y >>> step); y <= y + (x >>> step); z <= z - pcfk_pkg::atan_at(step);
          end else begin
            x <= x + (y >>> step); y <= y - (x >>> step); z <= z + pcfk_pkg::atan_at(step);
          end
          if (step == 5'(pcfk_pkg::CordicSteps - 1)) begin
            state <= S_EMIT;
          end
          step <= step + 5'd1;
        end
        S_EMIT: if (!out_valid || out_ready) begin
          logic signed [pcfk_pkg::AccW-1:0] ax, ay;
          ax = accx;
          ay = accy;
          if (k != 3'd0) begin
            ax = accx + pcfk_pkg::AccW'(x);
            ay = accy + pcfk_pkg::AccW'(y);
          end
          accx <= ax;
          accy <= ay;
          out_valid <= 1'b1;
          out_data.out_joint <= k;
          out_data.pos_x <= pcfk_pkg::to_pos(ax);
          out_data.pos_y <= pcfk_pkg::to_pos(ay);
          out_data.own_angle <= cur.angles[k];
          out_data.last_joint <= 4'(k) == cur.count - 4'd1;
          sum <= sum + cur.angles[k];
          k <= k + 3'd1;
          state <= (4'(k) == cur.count - 4'd1) ? S_IDLE : S_LOAD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/planar_chain_forward_kinematics.sv
// Planar chain forward kinematics, top level. A request adds a delta to one
// stored joint angle when it is taken; a request with apply_now also queues
// a walk of the chain that returns one result per joint in use, clamped to
// 2..8. The back end runs one CORDIC iteration a cycle; each link takes a
// load, 16 iterations and an emit, while joint 0 is emitted with no load;
// output stalls add to both. The back end returns to idle as it emits its last
// result and takes the next walk from idle. The front end keeps accepting
// requests while a walk runs and holds one pending walk; with a walk pending
// and the back end busy, the input is stalled.
`default_nettype none
module planar_chain_forward_kinematics (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pcfk_pkg::in_req_t in_data,
  input  wire logic in_valid,
  output logic in_ready,
  output pcfk_pkg::out_req_t out_data,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [3:0] joints_in_use;
  logic [7:1][15:0] link_len;
  pcfk_pkg::job_t job;
  logic job_valid, job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      joints_in_use <= 4'd8;
      link_len <= {7{16'd256}};
    end else if (cfg_we) begin
      if (cfg_index == pcfk_pkg::REG_JOINTS) joints_in_use <= cfg_data[3:0];
      else link_len[cfg_index] <= cfg_data;
    end
  end

  pcfk_front u_front (.clk, .rst, .in_data, .in_valid, .in_ready, .joints_in_use,
    .job, .job_valid, .job_ready);
  pcfk_back u_back (.clk, .rst, .job, .job_valid, .job_ready, .link_len,
    .out_data, .out_valid, .out_ready);
endmodule
`default_nettype wire

### hw/rtl/pcfk_checker.sv
// port checker for the planar chain block
`default_nettype none
module pcfk_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire pcfk_pkg::out_req_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_joint |=> !out_valid || out_data.out_joint == 3'd0)
    else $error("walk order");
  a_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_joint |=> !out_valid ||
      out_data.out_joint == $past(out_data.out_joint) + 3'd1) else $error("joint order");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_joint == 3'd0 |-> out_data.pos_x == 20'sd0 &&
      out_data.pos_y == 20'sd0) else $error("origin");
endmodule
bind planar_chain_forward_kinematics pcfk_checker u_chk (.clk, .rst, .out_valid,
  .out_ready, .out_data);
`default_nettype wire
